// ===== rtl/cfr_pkg.sv =====
package cfr_pkg;

	// Header and trailer sizes in bytes
	localparam logic [2:0]  INIT_HDR_LEN = 3'd5;
	localparam logic [2:0]  CONT_HDR_LEN = 3'd3;
	localparam logic [15:0] TRAILER_LEN  = 16'd4;

	// Byte positions inside a chunk header
	localparam logic [2:0] POS_CTRL  = 3'd0;
	localparam logic [2:0] POS_CH_HI = 3'd1;
	localparam logic [2:0] POS_CH_LO = 3'd2;
	localparam logic [2:0] POS_LN_HI = 3'd3;
	localparam logic [2:0] POS_SAT   = 3'd5;

	// Status codes
	localparam logic [2:0] ST_NONE       = 3'd0;
	localparam logic [2:0] ST_OK         = 3'd1;
	localparam logic [2:0] ST_SHORT      = 3'd2;
	localparam logic [2:0] ST_BAD_INIT   = 3'd3;
	localparam logic [2:0] ST_NO_CONT    = 3'd4;
	localparam logic [2:0] ST_CH_MISM    = 3'd5;
	localparam logic [2:0] ST_LEN_SHORT  = 3'd6;
	localparam logic [2:0] ST_CRC_MISM   = 3'd7;

	// CRC-32/ISO-HDLC, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
	} chunk_item_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic [2:0]  status;
		logic [7:0]  frame_control;
		logic [15:0] frame_channel;
	} frame_item_t;

	// Queued item: raw byte plus what the front already knows about it
	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
		logic       cont_bit;
	} queue_item_t;

	// Queue handshake from front to back
	typedef struct packed {
		logic        valid;
		queue_item_t item;
	} queue_link_t;

	// One byte through the CRC register, bitwise XOR tree
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/cfr_stream_if.sv =====
interface cfr_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/cfr_front.sv =====
module cfr_front #(
	parameter int QueueDepth = cfr_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	cfr_stream_if.sink          chunk,
	output cfr_pkg::queue_link_t link,
	input  logic                pop
);
	import cfr_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] Full    = CntW'(QueueDepth);

	queue_item_t     mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            do_pop;
	queue_item_t     item_in;

	// Classify on entry: continuation bit of the byte
	always_comb begin
		item_in.data_byte  = chunk.payload.data_byte;
		item_in.chunk_last = chunk.payload.chunk_last;
		item_in.cont_bit   = chunk.payload.data_byte[7];
	end

	assign chunk.ready = (count_q != Full);
	assign push        = chunk.valid && chunk.ready;
	assign do_pop      = pop && (count_q != '0);

	assign link.valid  = (count_q != '0);
	assign link.item   = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Full) else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");

endmodule

// ===== rtl/cfr_back.sv =====
module cfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfr_pkg::queue_link_t link,
	output logic                 pop,
	cfr_stream_if.source         frame
);
	import cfr_pkg::*;

	// Frame state
	logic        started_q;
	logic [7:0]  ctrl_q;
	logic [15:0] chan_q;
	logic [15:0] decl_len_q;
	logic [15:0] body_cnt_q;
	logic [2:0]  pos_q;
	logic [31:0] crc_q;
	logic [31:0] trailer_q;
	logic        rejected_q;
	logic [2:0]  pend_err_q;

	logic        started_d;
	logic [7:0]  ctrl_d;
	logic [15:0] chan_d;
	logic [15:0] decl_len_d;
	logic [15:0] body_cnt_d;
	logic [2:0]  pos_d;
	logic [31:0] crc_d;
	logic [31:0] trailer_d;
	logic        rejected_d;
	logic [2:0]  pend_err_d;

	// Output register
	logic        out_vld_q;
	frame_item_t out_q;
	frame_item_t res;

	logic        do_body;
	logic        is_short;
	logic [7:0]  b;

	assign pop         = link.valid && (!out_vld_q || frame.ready);
	assign frame.valid = out_vld_q;
	assign frame.payload = out_q;
	assign b           = link.item.data_byte;

	// Next state and result for the item at the queue head
	always_comb begin
		started_d  = started_q;
		ctrl_d     = ctrl_q;
		chan_d     = chan_q;
		decl_len_d = decl_len_q;
		body_cnt_d = body_cnt_q;
		pos_d      = pos_q;
		crc_d      = crc_q;
		trailer_d  = trailer_q;
		rejected_d = rejected_q;
		pend_err_d = pend_err_q;
		do_body    = 1'b0;
		is_short   = 1'b0;
		res        = '0;

		// header checks and field capture
		if (!rejected_q) begin
			if (!started_q) begin
				if (pos_q < INIT_HDR_LEN) begin
					case (pos_q)
						POS_CTRL: begin
							if (link.item.cont_bit) begin
								if (pend_err_d == ST_NONE) pend_err_d = ST_BAD_INIT;
								rejected_d = 1'b1;
							end else begin
								ctrl_d = b;
							end
						end
						POS_CH_HI: chan_d = {b, 8'h00};
						POS_CH_LO: chan_d = {chan_q[15:8], b};
						POS_LN_HI: decl_len_d = {b, 8'h00};
						default:   decl_len_d = {decl_len_q[15:8], b};
					endcase
					if (!rejected_d) begin
						crc_d = crc_byte(crc_q, b);
					end
				end else begin
					do_body = 1'b1;
				end
			end else begin
				case (pos_q)
					POS_CTRL: begin
						if (!link.item.cont_bit) begin
							if (pend_err_d == ST_NONE) pend_err_d = ST_NO_CONT;
							rejected_d = 1'b1;
						end
					end
					POS_CH_HI: begin
						if (b != chan_q[15:8]) begin
							if (pend_err_d == ST_NONE) pend_err_d = ST_CH_MISM;
							rejected_d = 1'b1;
						end
					end
					POS_CH_LO: begin
						if (b != chan_q[7:0]) begin
							if (pend_err_d == ST_NONE) pend_err_d = ST_CH_MISM;
							rejected_d = 1'b1;
						end
					end
					default: do_body = 1'b1;
				endcase
			end
		end

		// body byte: payload, trailer, or ignored past the declared length
		if (do_body && (body_cnt_q < decl_len_q)) begin
			if (decl_len_q >= TRAILER_LEN) begin
				if (body_cnt_q < decl_len_q - TRAILER_LEN) begin
					crc_d             = crc_byte(crc_q, b);
					res.payload_valid = 1'b1;
					res.payload_byte  = b;
				end else begin
					trailer_d = {trailer_q[23:0], b};
				end
			end
			body_cnt_d = body_cnt_q + 16'd1;
		end

		if (pos_q < POS_SAT) begin
			pos_d = pos_q + 3'd1;
		end

		// chunk end: report if short, failed, or frame complete
		if (link.item.chunk_last) begin
			is_short = started_q ? (pos_q < CONT_HDR_LEN) : (pos_q < INIT_HDR_LEN - 3'd1);
			if (is_short) begin
				res.status = ST_SHORT;
			end else if (pend_err_d != ST_NONE) begin
				res.status = pend_err_d;
			end else begin
				started_d = 1'b1;
				pos_d     = '0;
				if (body_cnt_d >= decl_len_d) begin
					if (decl_len_d < TRAILER_LEN) begin
						res.status = ST_LEN_SHORT;
					end else if (~crc_d == trailer_d) begin
						res.status        = ST_OK;
						res.frame_control = ctrl_d;
						res.frame_channel = chan_d;
					end else begin
						res.status = ST_CRC_MISM;
					end
				end
			end
			if (res.status != ST_NONE) begin
				started_d  = 1'b0;
				ctrl_d     = '0;
				chan_d     = '0;
				decl_len_d = '0;
				body_cnt_d = '0;
				pos_d      = '0;
				crc_d      = CRC_INIT;
				trailer_d  = '0;
				rejected_d = 1'b0;
				pend_err_d = ST_NONE;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			ctrl_q     <= '0;
			chan_q     <= '0;
			decl_len_q <= '0;
			body_cnt_q <= '0;
			pos_q      <= '0;
			crc_q      <= CRC_INIT;
			trailer_q  <= '0;
			rejected_q <= 1'b0;
			pend_err_q <= ST_NONE;
		end else if (pop) begin
			started_q  <= started_d;
			ctrl_q     <= ctrl_d;
			chan_q     <= chan_d;
			decl_len_q <= decl_len_d;
			body_cnt_q <= body_cnt_d;
			pos_q      <= pos_d;
			crc_q      <= crc_d;
			trailer_q  <= trailer_d;
			rejected_q <= rejected_d;
			pend_err_q <= pend_err_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop) begin
			out_vld_q <= 1'b1;
		end else if (frame.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_SAT) else $error("chunk position past saturation");

	a_idle_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res.status != ST_NONE |=> !started_q && pos_q == '0 && crc_q == CRC_INIT)
		else $error("state not cleared after report");

	a_payload_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.payload_valid |-> out_q.status == ST_NONE)
		else $error("payload byte together with a status");

endmodule

// ===== rtl/chunked_frame_reassembler_crc32.sv =====
// Channel  Dir  Item          Fields
// chunk    in   chunk byte    data_byte[7:0], chunk_last
// frame    out  result        payload_byte[7:0], payload_valid, status[2:0],
//                             frame_control[7:0], frame_channel[15:0]
//
// One item per cycle sustained while frame is ready; the bytewise CRC XOR
// tree in the back part is the longest path. An accepted item is written to
// the queue and moves to the output register when popped, valid from then on.
// Exactly one result per item.
// Reset clears all frame state and the queue at once; no clearing pass.
// Stalls on frame are absorbed by the queue (QueueDepth items) and the
// output register, then chunk ready drops.
module chunked_frame_reassembler_crc32 #(
	parameter int QueueDepth = cfr_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	cfr_stream_if.sink   chunk,
	cfr_stream_if.source frame
);
	import cfr_pkg::*;

	queue_link_t link;
	logic        pop;

	// Front: accept and classify into the queue
	cfr_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.chunk (chunk),
		.link  (link),
		.pop   (pop)
	);

	// Back: frame state, CRC, result register
	cfr_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.link  (link),
		.pop   (pop),
		.frame (frame)
	);

endmodule
